### hw/rtl/msce_pkg.sv
// Shared types and constants for the single-cycle MIPS32 subset executor.
// No dependencies; every other file in hw/rtl imports this package.
package msce_pkg;

	localparam int XLEN           = 32;
	localparam int NUM_REGS       = 32;
	localparam int REG_IDX_W      = 5;
	localparam int DATA_WORDS_DEF = 65536;
	localparam int INSTR_BYTES    = 4;
	localparam int IMM_W          = 16;
	localparam int WORD_SHIFT     = 2;
	localparam logic [REG_IDX_W-1:0] LINK_REG = 5'd31;

	typedef enum logic [1:0] {
		OP_EXEC   = 2'd0,
		OP_WR_REG = 2'd1,
		OP_WR_MEM = 2'd2,
		OP_SET_PC = 2'd3
	} op_code_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SYSCALL = 2'd1,
		ST_BAD_OPC = 2'd2,
		ST_BAD_FN  = 2'd3
	} status_t;

	// major opcodes
	localparam logic [5:0] OPC_SPECIAL = 6'h00;
	localparam logic [5:0] OPC_J       = 6'h02;
	localparam logic [5:0] OPC_JAL     = 6'h03;
	localparam logic [5:0] OPC_BEQ     = 6'h04;
	localparam logic [5:0] OPC_BNE     = 6'h05;
	localparam logic [5:0] OPC_ADDI    = 6'h08;
	localparam logic [5:0] OPC_ADDIU   = 6'h09;
	localparam logic [5:0] OPC_SLTI    = 6'h0A;
	localparam logic [5:0] OPC_ANDI    = 6'h0C;
	localparam logic [5:0] OPC_ORI     = 6'h0D;
	localparam logic [5:0] OPC_LUI     = 6'h0F;
	localparam logic [5:0] OPC_LW      = 6'h23;
	localparam logic [5:0] OPC_SW      = 6'h2B;

	// function codes of the special opcode
	localparam logic [5:0] FN_SLL     = 6'h00;
	localparam logic [5:0] FN_SRL     = 6'h02;
	localparam logic [5:0] FN_JR      = 6'h08;
	localparam logic [5:0] FN_SYSCALL = 6'h0C;
	localparam logic [5:0] FN_ADD     = 6'h20;
	localparam logic [5:0] FN_ADDU    = 6'h21;
	localparam logic [5:0] FN_SUB     = 6'h22;
	localparam logic [5:0] FN_SUBU    = 6'h23;
	localparam logic [5:0] FN_AND     = 6'h24;
	localparam logic [5:0] FN_OR      = 6'h25;
	localparam logic [5:0] FN_NOR     = 6'h27;
	localparam logic [5:0] FN_SLT     = 6'h2A;

	typedef struct packed {
		op_code_t             operation;
		logic [XLEN-1:0]      instruction;
		logic [REG_IDX_W-1:0] reg_index;
		logic [XLEN-1:0]      mem_address;
		logic [XLEN-1:0]      load_value;
	} cmd_t;

	typedef struct packed {
		status_t              status;
		logic [XLEN-1:0]      pc_after;
		logic                 dest_valid;
		logic [REG_IDX_W-1:0] dest_reg;
		logic [XLEN-1:0]      dest_value;
	} res_t;

	// outcome of one item, from the execute logic to the stage registers
	typedef struct packed {
		status_t              status;
		logic [XLEN-1:0]      pc_next;
		logic                 wr;
		logic [REG_IDX_W-1:0] wreg;
		logic [XLEN-1:0]      wval;
		logic                 is_load;
		logic                 mem_we;
		logic [XLEN-1:0]      mem_addr;
		logic [XLEN-1:0]      mem_wdata;
	} exec_t;

endpackage

### hw/rtl/msce_cmd_if.sv
// Input channel of the executor: valid/ready handshake carrying one cmd_t item.
// Depends on msce_pkg.
interface msce_cmd_if import msce_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### hw/rtl/msce_res_if.sv
// Result channel of the executor: valid/ready handshake carrying one res_t item.
// Depends on msce_pkg.
interface msce_res_if import msce_pkg::*; ();
	logic valid;
	logic ready;
	res_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

### hw/rtl/msce_regfile.sv
// 32 x 32 register file, one write port, two registered read ports.
// Entries read as zero until written; reads see a write of the same cycle.
// Depends on msce_pkg.
module msce_regfile import msce_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [REG_IDX_W-1:0] rd_addr_a,
	input  logic [REG_IDX_W-1:0] rd_addr_b,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_addr,
	input  logic [XLEN-1:0]      wr_data,
	output logic [XLEN-1:0]      rd_data_a,
	output logic [XLEN-1:0]      rd_data_b
);

	logic [XLEN-1:0]      regs [NUM_REGS];
	logic [NUM_REGS-1:0]  valid_q;
	logic [REG_IDX_W-1:0] addr_a_q;
	logic [REG_IDX_W-1:0] addr_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			regs[wr_addr] <= wr_data;
		end
	end

	// capture on read; while the reader holds, track later writes to its registers
	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_a_q  <= rd_addr_a;
			addr_b_q  <= rd_addr_b;
			rd_data_a <= (wr_en && wr_addr == rd_addr_a) ? wr_data :
				(valid_q[rd_addr_a] ? regs[rd_addr_a] : '0);
			rd_data_b <= (wr_en && wr_addr == rd_addr_b) ? wr_data :
				(valid_q[rd_addr_b] ? regs[rd_addr_b] : '0);
		end else begin
			if (wr_en && wr_addr == addr_a_q) begin
				rd_data_a <= wr_data;
			end
			if (wr_en && wr_addr == addr_b_q) begin
				rd_data_b <= wr_data;
			end
		end
	end

endmodule

### hw/rtl/msce_exec.sv
// Decode and execute of one item: ALU, branch and jump targets, preloads.
// Purely combinational; depends on msce_pkg.
module msce_exec import msce_pkg::*; (
	input  op_code_t             operation,
	input  logic [XLEN-1:0]      instruction,
	input  logic [REG_IDX_W-1:0] reg_index,
	input  logic [XLEN-1:0]      mem_address,
	input  logic [XLEN-1:0]      load_value,
	input  logic [XLEN-1:0]      pc,
	input  logic [XLEN-1:0]      opnd_a,
	input  logic [XLEN-1:0]      opnd_b,
	output exec_t                ex
);

	logic [5:0]           major;
	logic [5:0]           fn;
	logic [REG_IDX_W-1:0] rt;
	logic [REG_IDX_W-1:0] rd;
	logic [4:0]           sh;
	logic [XLEN-1:0]      sext;
	logic [XLEN-1:0]      zext;
	logic [XLEN-1:0]      next_pc;
	logic [XLEN-1:0]      far_pc;
	logic [XLEN-1:0]      br_pc;
	exec_t                raw;

	assign major   = instruction[31:26];
	assign fn      = instruction[5:0];
	assign rt      = instruction[20:16];
	assign rd      = instruction[15:11];
	assign sh      = instruction[10:6];
	assign sext    = {{(XLEN-IMM_W){instruction[IMM_W-1]}}, instruction[IMM_W-1:0]};
	assign zext    = {{(XLEN-IMM_W){1'b0}}, instruction[IMM_W-1:0]};
	assign next_pc = pc + XLEN'(INSTR_BYTES);
	assign far_pc  = {next_pc[31:28], instruction[25:0], 2'b00};
	assign br_pc   = next_pc + {sext[XLEN-3:0], 2'b00};

	always_comb begin
		raw           = '0;
		raw.status    = ST_OK;
		raw.pc_next   = pc;
		raw.mem_addr  = opnd_a + sext;
		raw.mem_wdata = opnd_b;
		case (operation)
			OP_WR_REG: begin
				raw.wr   = 1'b1;
				raw.wreg = reg_index;
				raw.wval = load_value;
			end
			OP_WR_MEM: begin
				raw.mem_we    = 1'b1;
				raw.mem_addr  = mem_address;
				raw.mem_wdata = load_value;
			end
			OP_SET_PC: begin
				raw.pc_next = load_value;
			end
			default: begin
				raw.pc_next = next_pc;
				case (major)
					OPC_SPECIAL: begin
						raw.wreg = rd;
						raw.wr   = 1'b1;
						case (fn)
							FN_JR: begin
								raw.wr      = 1'b0;
								raw.pc_next = opnd_a;
							end
							FN_SYSCALL: begin
								raw.wr     = 1'b0;
								raw.status = ST_SYSCALL;
							end
							FN_ADD, FN_ADDU: raw.wval = opnd_a + opnd_b;
							FN_SUB, FN_SUBU: raw.wval = opnd_a - opnd_b;
							FN_AND:  raw.wval = opnd_a & opnd_b;
							FN_OR:   raw.wval = opnd_a | opnd_b;
							FN_NOR:  raw.wval = ~(opnd_a | opnd_b);
							FN_SLT:  raw.wval = XLEN'($signed(opnd_a) < $signed(opnd_b));
							FN_SLL:  raw.wval = opnd_b << sh;
							FN_SRL:  raw.wval = opnd_b >> sh;
							default: begin
								raw.wr     = 1'b0;
								raw.status = ST_BAD_FN;
							end
						endcase
					end
					OPC_J: raw.pc_next = far_pc;
					OPC_JAL: begin
						raw.wr      = 1'b1;
						raw.wreg    = LINK_REG;
						raw.wval    = next_pc;
						raw.pc_next = far_pc;
					end
					OPC_BEQ: begin
						if (opnd_a == opnd_b) begin
							raw.pc_next = br_pc;
						end
					end
					OPC_BNE: begin
						if (opnd_a != opnd_b) begin
							raw.pc_next = br_pc;
						end
					end
					OPC_ADDI, OPC_ADDIU: begin
						raw.wr   = 1'b1;
						raw.wreg = rt;
						raw.wval = opnd_a + sext;
					end
					OPC_SLTI: begin
						raw.wr   = 1'b1;
						raw.wreg = rt;
						raw.wval = XLEN'($signed(opnd_a) < $signed(sext));
					end
					OPC_ANDI: begin
						raw.wr   = 1'b1;
						raw.wreg = rt;
						raw.wval = opnd_a & zext;
					end
					OPC_ORI: begin
						raw.wr   = 1'b1;
						raw.wreg = rt;
						raw.wval = opnd_a | zext;
					end
					OPC_LUI: begin
						raw.wr   = 1'b1;
						raw.wreg = rt;
						raw.wval = zext << IMM_W;
					end
					OPC_LW: begin
						raw.wr      = 1'b1;
						raw.wreg    = rt;
						raw.is_load = 1'b1;
					end
					OPC_SW: raw.mem_we = 1'b1;
					default: raw.status = ST_BAD_OPC;
				endcase
			end
		endcase
	end

	// drop writes to r0
	always_comb begin
		ex = raw;
		if (!(raw.wr && raw.wreg != '0)) begin
			ex.wr      = 1'b0;
			ex.wreg    = '0;
			ex.wval    = '0;
			ex.is_load = 1'b0;
		end
	end

endmodule

### hw/rtl/mips_single_cycle_execute_top.sv
// Single-cycle MIPS32 integer-subset executor, top level.
// Each item passes the s1 registers, then the s2 registers that offer its result.
// Throughput: one item per cycle while res.ready holds; lw reads the data memory
// port in the same pass, with its data forwarded from the memory read register.
// Reset: registers read zero and the pc is zero at once; data memory is
// undefined until written. Depends on msce_pkg, the channel interfaces,
// msce_regfile and msce_exec.
module mips_single_cycle_execute_top import msce_pkg::*; #(
	parameter int DATA_WORDS = DATA_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	msce_cmd_if.sink    cmd,
	msce_res_if.source  res
);

	// memory depth is a power of two; the word index wraps
	localparam int ADDR_W = $clog2(DATA_WORDS);

	logic                 s1_valid_q;
	op_code_t             op_s1;
	logic [XLEN-1:0]      instr_s1;
	logic [REG_IDX_W-1:0] reg_index_s1;
	logic [XLEN-1:0]      mem_address_s1;
	logic [XLEN-1:0]      load_value_s1;

	logic                 s2_valid_q;
	status_t              status_s2;
	logic [XLEN-1:0]      pc_s2;
	logic                 dest_valid_s2;
	logic [REG_IDX_W-1:0] dest_reg_s2;
	logic [XLEN-1:0]      dest_value_s2;
	logic                 load_s2;

	logic [XLEN-1:0]      pc_q;
	logic                 wb_pend_q;
	logic [XLEN-1:0]      mem_rdata_q;
	logic [XLEN-1:0]      dmem [DATA_WORDS];

	logic                 accept;
	logic                 s2_adv;
	logic                 wb_en;
	logic [XLEN-1:0]      wb_data;
	logic [XLEN-1:0]      rf_a;
	logic [XLEN-1:0]      rf_b;
	logic [XLEN-1:0]      opnd_a;
	logic [XLEN-1:0]      opnd_b;
	logic [ADDR_W-1:0]    slot;
	exec_t                ex;

	assign s2_adv    = s1_valid_q && (!s2_valid_q || res.ready);
	assign cmd.ready = !s1_valid_q || s2_adv;
	assign accept    = cmd.valid && cmd.ready;

	// register write happens in the first cycle an item sits in the result stage
	assign wb_en   = wb_pend_q && dest_valid_s2;
	assign wb_data = load_s2 ? mem_rdata_q : dest_value_s2;

	msce_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (cmd.payload.instruction[25:21]),
		.rd_addr_b (cmd.payload.instruction[20:16]),
		.wr_en     (wb_en),
		.wr_addr   (dest_reg_s2),
		.wr_data   (wb_data),
		.rd_data_a (rf_a),
		.rd_data_b (rf_b)
	);

	// forward the write of the item just ahead
	assign opnd_a = (wb_en && dest_reg_s2 == instr_s1[25:21]) ? wb_data : rf_a;
	assign opnd_b = (wb_en && dest_reg_s2 == instr_s1[20:16]) ? wb_data : rf_b;

	msce_exec u_exec (
		.operation   (op_s1),
		.instruction (instr_s1),
		.reg_index   (reg_index_s1),
		.mem_address (mem_address_s1),
		.load_value  (load_value_s1),
		.pc          (pc_q),
		.opnd_a      (opnd_a),
		.opnd_b      (opnd_b),
		.ex          (ex)
	);

	assign slot = ex.mem_addr[ADDR_W+WORD_SHIFT-1:WORD_SHIFT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			pc_q       <= '0;
			wb_pend_q  <= 1'b0;
		end else begin
			wb_pend_q <= s2_adv;
			if (cmd.ready) begin
				s1_valid_q <= cmd.valid;
			end
			if (s2_adv) begin
				s2_valid_q <= 1'b1;
				pc_q       <= ex.pc_next;
			end else if (res.ready) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1          <= cmd.payload.operation;
			instr_s1       <= cmd.payload.instruction;
			reg_index_s1   <= cmd.payload.reg_index;
			mem_address_s1 <= cmd.payload.mem_address;
			load_value_s1  <= cmd.payload.load_value;
		end
		if (s2_adv) begin
			status_s2     <= ex.status;
			pc_s2         <= ex.pc_next;
			dest_valid_s2 <= ex.wr;
			dest_reg_s2   <= ex.wreg;
			dest_value_s2 <= ex.wval;
			load_s2       <= ex.is_load;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv && ex.mem_we) begin
			dmem[slot] <= ex.mem_wdata;
		end
		if (s2_adv && ex.is_load) begin
			mem_rdata_q <= dmem[slot];
		end
	end

	assign res.valid              = s2_valid_q;
	assign res.payload.status     = status_s2;
	assign res.payload.pc_after   = pc_s2;
	assign res.payload.dest_valid = dest_valid_s2;
	assign res.payload.dest_reg   = dest_reg_s2;
	assign res.payload.dest_value = wb_data;

endmodule

### sim/tb_top.sv
// Self-checking bench for mips_single_cycle_execute_top: directed and random items
// through the cmd/res channels, each result checked against an in-bench executor.
// Depends on msce_pkg, msce_cmd_if, msce_res_if and the executor RTL.
module tb_top;
	import msce_pkg::*;

	localparam logic [5:0]  OPC_UNUSED = 6'h3F;
	localparam logic [5:0]  FN_UNUSED  = 6'h3F;
	localparam logic [31:0] MEM_SPAN   = DATA_WORDS_DEF << WORD_SHIFT;

	logic clk;
	logic arst_n;
	int unsigned cycle_cnt = 0;
	logic steady;
	int error_count = 0;

	msce_cmd_if cmd_ch();
	msce_res_if res_ch();

	mips_single_cycle_execute_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	// architectural state of the executor as the bench sees it
	logic [XLEN-1:0] gpr [NUM_REGS];
	logic [XLEN-1:0] core_pc;
	logic [XLEN-1:0] dmem [int unsigned];

	cmd_t issue_q [$];
	res_t retire_q [$];

	function automatic int unsigned mem_slot(input logic [XLEN-1:0] addr);
		return (addr >> WORD_SHIFT) % DATA_WORDS_DEF;
	endfunction

	function automatic res_t run_core_item(input cmd_t c);
		res_t r;
		status_t st;
		logic [5:0] opc, fn;
		logic [REG_IDX_W-1:0] rs_i, rt_i, rd_i, sh, wreg;
		logic [XLEN-1:0] va, vb, simm, zimm, pc_inc, jump_tgt, wval;
		logic wr;
		st = ST_OK;
		wr = 1'b0;
		wreg = '0;
		wval = '0;
		case (c.operation)
		OP_WR_REG: begin
			wr = 1'b1;
			wreg = c.reg_index;
			wval = c.load_value;
		end
		OP_WR_MEM: dmem[mem_slot(c.mem_address)] = c.load_value;
		OP_SET_PC: core_pc = c.load_value;
		OP_EXEC: begin
			opc = c.instruction[31:26];
			rs_i = c.instruction[25:21];
			rt_i = c.instruction[20:16];
			rd_i = c.instruction[15:11];
			sh = c.instruction[10:6];
			fn = c.instruction[5:0];
			va = gpr[rs_i];
			vb = gpr[rt_i];
			simm = {{(XLEN-IMM_W){c.instruction[IMM_W-1]}}, c.instruction[IMM_W-1:0]};
			zimm = {{(XLEN-IMM_W){1'b0}}, c.instruction[IMM_W-1:0]};
			pc_inc = core_pc + INSTR_BYTES;
			jump_tgt = {pc_inc[31:28], c.instruction[25:0], 2'b00};
			core_pc = pc_inc;
			case (opc)
			OPC_SPECIAL: begin
				case (fn)
				FN_JR: core_pc = va;
				FN_SYSCALL: st = ST_SYSCALL;
				FN_ADD, FN_ADDU: begin
					wr = 1'b1; wreg = rd_i; wval = va + vb;
				end
				FN_SUB, FN_SUBU: begin
					wr = 1'b1; wreg = rd_i; wval = va - vb;
				end
				FN_AND: begin
					wr = 1'b1; wreg = rd_i; wval = va & vb;
				end
				FN_OR: begin
					wr = 1'b1; wreg = rd_i; wval = va | vb;
				end
				FN_NOR: begin
					wr = 1'b1; wreg = rd_i; wval = ~(va | vb);
				end
				FN_SLT: begin
					wr = 1'b1; wreg = rd_i;
					wval = ($signed(va) < $signed(vb)) ? 32'd1 : 32'd0;
				end
				FN_SLL: begin
					wr = 1'b1; wreg = rd_i; wval = vb << sh;
				end
				FN_SRL: begin
					wr = 1'b1; wreg = rd_i; wval = vb >> sh;
				end
				default: st = ST_BAD_FN;
				endcase
			end
			OPC_J: core_pc = jump_tgt;
			OPC_JAL: begin
				wr = 1'b1; wreg = LINK_REG; wval = pc_inc; core_pc = jump_tgt;
			end
			OPC_BEQ: if (va == vb) core_pc = pc_inc + (simm << WORD_SHIFT);
			OPC_BNE: if (va != vb) core_pc = pc_inc + (simm << WORD_SHIFT);
			OPC_ADDI, OPC_ADDIU: begin
				wr = 1'b1; wreg = rt_i; wval = va + simm;
			end
			OPC_SLTI: begin
				wr = 1'b1; wreg = rt_i;
				wval = ($signed(va) < $signed(simm)) ? 32'd1 : 32'd0;
			end
			OPC_ANDI: begin
				wr = 1'b1; wreg = rt_i; wval = va & zimm;
			end
			OPC_ORI: begin
				wr = 1'b1; wreg = rt_i; wval = va | zimm;
			end
			OPC_LUI: begin
				wr = 1'b1; wreg = rt_i; wval = zimm << IMM_W;
			end
			OPC_LW: begin
				wr = 1'b1; wreg = rt_i;
				wval = dmem.exists(mem_slot(va + simm)) ? dmem[mem_slot(va + simm)] : '0;
			end
			OPC_SW: dmem[mem_slot(va + simm)] = vb;
			default: st = ST_BAD_OPC;
			endcase
		end
		endcase
		// r0 swallows every write
		if (wr && wreg != '0) begin
			gpr[wreg] = wval;
		end else begin
			wr = 1'b0; wreg = '0; wval = '0;
		end
		r.status = st;
		r.pc_after = core_pc;
		r.dest_valid = wr;
		r.dest_reg = wreg;
		r.dest_value = wval;
		return r;
	endfunction

	function automatic logic [XLEN-1:0] enc_r(input logic [5:0] fn, input logic [4:0] rd,
			input logic [4:0] rs, input logic [4:0] rt, input logic [4:0] sh);
		return {OPC_SPECIAL, rs, rt, rd, sh, fn};
	endfunction

	function automatic logic [XLEN-1:0] enc_i(input logic [5:0] opc, input logic [4:0] rt,
			input logic [4:0] rs, input logic [IMM_W-1:0] imm);
		return {opc, rs, rt, imm};
	endfunction

	function automatic logic [XLEN-1:0] enc_j(input logic [5:0] opc, input logic [25:0] tgt);
		return {opc, tgt};
	endfunction

	function automatic logic [XLEN-1:0] pick_value();
		case ($urandom_range(0, 7))
		0: return 32'h0000_0000;
		1: return 32'hFFFF_FFFF;
		2: return 32'h8000_0000;
		3: return 32'h7FFF_FFFF;
		4: return $urandom_range(0, 255);
		default: return $urandom();
		endcase
	endfunction

	// everything but lw, which only goes out where its word is known to be written
	function automatic logic [XLEN-1:0] rand_legal_instr();
		logic [5:0] code;
		logic [XLEN-1:0] w;
		w = $urandom();
		if ($urandom_range(1)) begin
			case ($urandom_range(0, 11))
			0: code = FN_SLL;
			1: code = FN_SRL;
			2: code = FN_JR;
			3: code = FN_SYSCALL;
			4: code = FN_ADD;
			5: code = FN_ADDU;
			6: code = FN_SUB;
			7: code = FN_SUBU;
			8: code = FN_AND;
			9: code = FN_OR;
			10: code = FN_NOR;
			default: code = FN_SLT;
			endcase
			w[31:26] = OPC_SPECIAL;
			w[5:0] = code;
		end else begin
			case ($urandom_range(0, 10))
			0: code = OPC_J;
			1: code = OPC_JAL;
			2: code = OPC_BEQ;
			3: code = OPC_BNE;
			4: code = OPC_ADDI;
			5: code = OPC_ADDIU;
			6: code = OPC_SLTI;
			7: code = OPC_ANDI;
			8: code = OPC_ORI;
			9: code = OPC_LUI;
			default: code = OPC_SW;
			endcase
			w[31:26] = code;
		end
		return w;
	endfunction

	// unused fields carry random bits
	function automatic cmd_t rand_cmd(input op_code_t op);
		cmd_t c;
		c.operation = op;
		c.instruction = $urandom();
		c.reg_index = REG_IDX_W'($urandom());
		c.mem_address = $urandom();
		c.load_value = $urandom();
		return c;
	endfunction

	function automatic void add_exec(input logic [XLEN-1:0] w);
		cmd_t c;
		c = rand_cmd(OP_EXEC);
		c.instruction = w;
		issue_q.push_back(c);
	endfunction

	function automatic void add_reg(input logic [4:0] idx, input logic [XLEN-1:0] val);
		cmd_t c;
		c = rand_cmd(OP_WR_REG);
		c.reg_index = idx;
		c.load_value = val;
		issue_q.push_back(c);
	endfunction

	function automatic void add_mem(input logic [XLEN-1:0] addr, input logic [XLEN-1:0] val);
		cmd_t c;
		c = rand_cmd(OP_WR_MEM);
		c.mem_address = addr;
		c.load_value = val;
		issue_q.push_back(c);
	endfunction

	function automatic void add_pc(input logic [XLEN-1:0] val);
		cmd_t c;
		c = rand_cmd(OP_SET_PC);
		c.load_value = val;
		issue_q.push_back(c);
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 100)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		for (int i = 0; i < NUM_REGS; i++)
			gpr[i] = '0;
		core_pc = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk)
		cycle_cnt <= cycle_cnt + 1;

	// window where neither side idles
	assign steady = (cycle_cnt >= 800) && (cycle_cnt < 1400);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.payload <= '0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready)
				retire_q.push_back(run_core_item(cmd_ch.payload));
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (issue_q.size() != 0 && (steady || $urandom_range(99) >= 36)) begin
					cmd_ch.valid <= 1'b1;
					cmd_ch.payload <= issue_q.pop_front();
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_result
		res_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (retire_q.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending, pc_after %h",
						res_ch.payload.pc_after));
				end else begin
					want = retire_q.pop_front();
					if (res_ch.payload.status !== want.status)
						report_mismatch($sformatf("status got %0d want %0d",
							res_ch.payload.status, want.status));
					if (res_ch.payload.pc_after !== want.pc_after)
						report_mismatch($sformatf("pc_after got %h want %h",
							res_ch.payload.pc_after, want.pc_after));
					if (res_ch.payload.dest_valid !== want.dest_valid)
						report_mismatch($sformatf("dest_valid got %b want %b",
							res_ch.payload.dest_valid, want.dest_valid));
					if (res_ch.payload.dest_reg !== want.dest_reg)
						report_mismatch($sformatf("dest_reg got %0d want %0d",
							res_ch.payload.dest_reg, want.dest_reg));
					if (res_ch.payload.dest_value !== want.dest_value)
						report_mismatch($sformatf("dest_value got %h want %h",
							res_ch.payload.dest_value, want.dest_value));
				end
			end
			res_ch.ready <= steady || ($urandom_range(99) >= 36);
		end
	end

	initial begin
		logic [4:0] base_r, alt_r, data_r;
		logic [IMM_W-1:0] imm, imm2;
		logic [XLEN-1:0] base, eff, off, off2, w, v;

		// extremes, r0 discard, wrap, signed compare
		add_reg(5'd1, 32'h7FFF_FFFF);
		add_reg(5'd2, 32'h8000_0000);
		add_reg(5'd0, 32'hFFFF_FFFF);
		add_reg(5'd31, 32'hFFFF_FFFF);
		add_exec(enc_r(FN_ADD, 5'd3, 5'd1, 5'd1, 5'd0));
		add_exec(enc_r(FN_SUBU, 5'd4, 5'd2, 5'd1, 5'd31));
		add_exec(enc_r(FN_NOR, 5'd0, 5'd1, 5'd2, 5'd0));
		add_exec(enc_r(FN_SLT, 5'd5, 5'd2, 5'd1, 5'd0));
		add_exec(enc_r(FN_SLL, 5'd6, 5'd0, 5'd31, 5'd31));
		add_exec(enc_r(FN_SRL, 5'd7, 5'd0, 5'd31, 5'd31));
		add_exec(enc_i(OPC_ADDI, 5'd8, 5'd2, 16'hFFFF));
		add_exec(enc_i(OPC_SLTI, 5'd9, 5'd1, 16'h8000));
		add_exec(enc_i(OPC_ANDI, 5'd10, 5'd31, 16'hFFFF));
		add_exec(enc_i(OPC_LUI, 5'd11, 5'd31, 16'hFFFF));
		// pc wraps on the increment, so the jump region comes from the new pc
		add_pc(32'hFFFF_FFFC);
		add_exec(enc_j(OPC_JAL, 26'h3FF_FFFF));
		add_exec(enc_i(OPC_BEQ, 5'd0, 5'd0, 16'h8000));
		add_exec(enc_i(OPC_BNE, 5'd1, 5'd1, 16'h7FFF));
		add_exec(enc_r(FN_JR, 5'd0, 5'd2, 5'd0, 5'd0));
		add_exec(enc_j(OPC_J, 26'h0));
		add_exec(enc_r(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0));
		add_exec(enc_j(OPC_UNUSED, 26'h0));
		add_exec(enc_r(FN_UNUSED, 5'd3, 5'd1, 5'd2, 5'd0));
		// memory: top word through a preload, a store and load that share a word
		add_mem(32'hFFFF_FFFF, 32'hA5A5_5A5A);
		add_exec(enc_i(OPC_LW, 5'd12, 5'd0, 16'hFFFF));
		add_exec(enc_i(OPC_SW, 5'd2, 5'd0, 16'h7FFC));
		add_exec(enc_i(OPC_LW, 5'd13, 5'd0, 16'h7FFF));

		while (issue_q.size() < 1530) begin
			base_r = 5'($urandom());
			alt_r = 5'($urandom_range(1, 31));
			data_r = 5'($urandom());
			imm = IMM_W'($urandom());
			imm2 = IMM_W'($urandom());
			base = pick_value();
			off = {{(XLEN-IMM_W){imm[IMM_W-1]}}, imm};
			off2 = {{(XLEN-IMM_W){imm2[IMM_W-1]}}, imm2};
			eff = ((base_r == 5'd0) ? 32'h0 : base) + off;
			case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7, 8: add_exec(rand_legal_instr());
			9, 10: begin
				w = $urandom();
				if (w[31:26] == OPC_LW)
					w[31:26] = OPC_SW;
				add_exec(w);
			end
			11, 12, 13: begin
				// preload base and word, then load it; the address may wrap
				add_reg(base_r, base);
				add_mem((eff ^ $urandom_range(0, 3)) + $urandom() * MEM_SPAN, $urandom());
				add_exec(enc_i(OPC_LW, 5'($urandom()), base_r, imm));
			end
			14: begin
				v = pick_value();
				add_reg(base_r, v);
				add_reg(data_r, $urandom_range(1) ? v : v ^ (32'h1 << $urandom_range(31)));
				add_exec(enc_i($urandom_range(1) ? OPC_BEQ : OPC_BNE, data_r, base_r, imm));
			end
			15, 16: add_reg(5'($urandom()), pick_value());
			17: add_mem($urandom(), $urandom());
			18: add_pc(pick_value());
			default: begin
				// store, then load the same word through another base
				add_reg(base_r, base);
				add_exec(enc_i(OPC_SW, data_r, base_r, imm));
				add_reg(alt_r, eff - off2 + $urandom() * MEM_SPAN);
				add_exec(enc_i(OPC_LW, 5'($urandom()), alt_r, imm2));
			end
			endcase
		end

		wait (arst_n === 1'b1);
		wait (issue_q.size() == 0 && !cmd_ch.valid && retire_q.size() == 0);
		repeat (6) @(posedge clk);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
